// ===== hw/rtl/rcs_pkg.sv =====
// Shared types, constants and helpers for the characteristic speed pipeline.
`default_nettype none
package rcs_pkg;

  localparam int SPACE_DIMS = 3;
  localparam int QF = 24;

  localparam logic signed [24:0] Q_HALF   = 25'sh0800000;
  localparam logic        [23:0] Q_HALF_U = 24'h800000;
  localparam logic signed [25:0] Q_ONE    = 26'sh1000000;
  localparam logic signed [49:0] Q_ONE2   = 50'sh1000000000000;

  localparam int SQ_BITS   = 32;
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = SQ_BITS / SQ_STEPS;

  localparam int DIV_QBITS  = 42;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = DIV_QBITS / DIV_STEPS;

  localparam logic [DIV_QBITS-1:0] TERM_LIM = DIV_QBITS'(64'h10000000000);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic        [30:0] lapse_value;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [25:0] vel_x;
    logic signed [25:0] vel_y;
    logic signed [25:0] vel_z;
    logic        [24:0] vel_sq;
    logic        [24:0] sound_sq;
    logic signed [25:0] norm_x;
    logic signed [25:0] norm_y;
    logic signed [25:0] norm_z;
  } in_t;

  typedef struct packed {
    logic        [30:0] alpha;
    logic signed [62:0] aq;
    logic signed [35:0] nb;
    logic signed [31:0] mat;
    logic        [24:0] w;
    logic               bad;
  } sq_side_t;

  typedef struct packed {
    logic [63:0] rad_c;
    logic [63:0] rad_r;
    sq_side_t    side;
  } front_t;

  typedef struct packed {
    logic signed [35:0] nb;
    logic signed [31:0] mat;
    logic               bad;
  } div_side_t;

  typedef struct packed {
    logic [DIV_QBITS-1:0] quot;
    logic                 neg;
    logic                 ovf;
  } div_res_t;

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > S32_MAX) y = S32_MAX;
    if (x < S32_MIN) y = S32_MIN;
    return y[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rcs_in_if.sv =====
// Input channel: one grid point per beat.
`default_nettype none
interface rcs_in_if;
  logic               valid;
  logic               ready;
  logic        [30:0] lapse_value;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;
  logic signed [25:0] vel_x;
  logic signed [25:0] vel_y;
  logic signed [25:0] vel_z;
  logic        [24:0] vel_sq;
  logic        [24:0] sound_sq;
  logic signed [25:0] norm_x;
  logic signed [25:0] norm_y;
  logic signed [25:0] norm_z;

  modport source (output valid, lapse_value, shift_x, shift_y, shift_z, vel_x, vel_y, vel_z,
                  vel_sq, sound_sq, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, lapse_value, shift_x, shift_y, shift_z, vel_x, vel_y, vel_z,
                vel_sq, sound_sq, norm_x, norm_y, norm_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rcs_out_if.sv =====
// Output channel: three speeds and a flag per beat.
`default_nettype none
interface rcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_minus;
  logic signed [31:0] speed_material;
  logic signed [31:0] speed_plus;
  logic               invalid_flag;

  modport source (output valid, speed_minus, speed_material, speed_plus, invalid_flag,
                  input ready);
  modport sink (input valid, speed_minus, speed_material, speed_plus, invalid_flag,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rcs_front.sv =====
// Front pipeline: dot products, material speed, root argument, seven stages.
`default_nettype none
module rcs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  rcs_pkg::in_t    in_i,
  output logic            vld_o,
  output rcs_pkg::front_t fr_o
);

  logic [6:0] vld_q;

  logic signed [25:0] nrm [3];
  logic signed [31:0] sft [3];
  logic signed [25:0] vel [3];

  assign nrm[0] = in_i.norm_x;
  assign nrm[1] = in_i.norm_y;
  assign nrm[2] = in_i.norm_z;
  assign sft[0] = in_i.shift_x;
  assign sft[1] = in_i.shift_y;
  assign sft[2] = in_i.shift_z;
  assign vel[0] = in_i.vel_x;
  assign vel[1] = in_i.vel_y;
  assign vel[2] = in_i.vel_z;

  // stage 1
  logic signed [57:0] pb_d [3];
  logic signed [51:0] pv_d [3];
  logic signed [57:0] s1_pb_q [3];
  logic signed [51:0] s1_pv_q [3];
  logic        [49:0] s1_vc_q;
  logic        [30:0] s1_alpha_q;
  logic        [24:0] s1_v2_q;
  logic        [24:0] s1_cs2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (k < rcs_pkg::SPACE_DIMS) begin
        pb_d[k] = 58'(nrm[k]) * 58'(sft[k]);
        pv_d[k] = 52'(nrm[k]) * 52'(vel[k]);
      end else begin
        pb_d[k] = '0;
        pv_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pb_q    <= pb_d;
      s1_pv_q    <= pv_d;
      s1_vc_q    <= 50'(in_i.vel_sq) * 50'(in_i.sound_sq);
      s1_alpha_q <= in_i.lapse_value;
      s1_v2_q    <= in_i.vel_sq;
      s1_cs2_q   <= in_i.sound_sq;
    end
  end

  // stage 2
  logic signed [59:0] nbsum_d;
  logic signed [53:0] nvsum_d;
  logic signed [51:0] wx_d;
  logic signed [59:0] s2_nbsum_q;
  logic signed [35:0] s2_nb_q;
  logic signed [29:0] s2_vn_q;
  logic signed [27:0] s2_w_q;
  logic signed [25:0] s2_omc_q;
  logic signed [25:0] s2_omv_q;
  logic        [30:0] s2_alpha_q;
  logic        [24:0] s2_cs2_q;

  always_comb begin
    nbsum_d = 60'(s1_pb_q[0]) + 60'(s1_pb_q[1]) + 60'(s1_pb_q[2]);
    nvsum_d = 54'(s1_pv_q[0]) + 54'(s1_pv_q[1]) + 54'(s1_pv_q[2]);
    wx_d    = 52'(rcs_pkg::Q_ONE2) - $signed(52'(s1_vc_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_nbsum_q <= nbsum_d;
      s2_nb_q    <= 36'((nbsum_d + 60'(rcs_pkg::Q_HALF)) >>> rcs_pkg::QF);
      s2_vn_q    <= 30'((nvsum_d + 54'(rcs_pkg::Q_HALF)) >>> rcs_pkg::QF);
      s2_w_q     <= 28'((wx_d + 52'(rcs_pkg::Q_HALF)) >>> rcs_pkg::QF);
      s2_omc_q   <= rcs_pkg::Q_ONE - $signed(26'(s1_cs2_q));
      s2_omv_q   <= rcs_pkg::Q_ONE - $signed(26'(s1_v2_q));
      s2_alpha_q <= s1_alpha_q;
      s2_cs2_q   <= s1_cs2_q;
    end
  end

  // stage 3
  logic signed [31:0] alpha2_s;
  logic signed [61:0] s3_av_q;
  logic signed [55:0] s3_vq_q;
  logic signed [59:0] s3_nbsum_q;
  logic signed [35:0] s3_nb_q;
  logic signed [29:0] s3_vn_q;
  logic signed [27:0] s3_w_q;
  logic signed [25:0] s3_omv_q;
  logic        [30:0] s3_alpha_q;
  logic        [24:0] s3_cs2_q;

  assign alpha2_s = $signed(32'(s2_alpha_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_av_q    <= 62'(alpha2_s) * 62'(s2_vn_q);
      s3_vq_q    <= 56'(s2_vn_q) * 56'(s2_omc_q);
      s3_nbsum_q <= s2_nbsum_q;
      s3_nb_q    <= s2_nb_q;
      s3_vn_q    <= s2_vn_q;
      s3_w_q     <= s2_w_q;
      s3_omv_q   <= s2_omv_q;
      s3_alpha_q <= s2_alpha_q;
      s3_cs2_q   <= s2_cs2_q;
    end
  end

  // stage 4
  logic signed [62:0] mx_d;
  logic signed [38:0] matw_d;
  logic signed [31:0] s4_mat_q;
  logic signed [31:0] s4_q_q;
  logic signed [35:0] s4_nb_q;
  logic signed [29:0] s4_vn_q;
  logic signed [27:0] s4_w_q;
  logic signed [25:0] s4_omv_q;
  logic        [30:0] s4_alpha_q;
  logic        [24:0] s4_cs2_q;

  always_comb begin
    mx_d   = 63'(s3_av_q) - 63'(s3_nbsum_q) + 63'(rcs_pkg::Q_HALF);
    matw_d = 39'(mx_d >>> rcs_pkg::QF);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_mat_q   <= rcs_pkg::sat32(64'(matw_d));
      s4_q_q     <= 32'((56'(s3_vq_q) + 56'(rcs_pkg::Q_HALF)) >>> rcs_pkg::QF);
      s4_nb_q    <= s3_nb_q;
      s4_vn_q    <= s3_vn_q;
      s4_w_q     <= s3_w_q;
      s4_omv_q   <= s3_omv_q;
      s4_alpha_q <= s3_alpha_q;
      s4_cs2_q   <= s3_cs2_q;
    end
  end

  // stage 5
  logic signed [31:0] alpha4_s;
  logic signed [61:0] s5_vnq_q;
  logic signed [62:0] s5_aq_q;
  logic signed [31:0] s5_mat_q;
  logic signed [35:0] s5_nb_q;
  logic signed [27:0] s5_w_q;
  logic signed [25:0] s5_omv_q;
  logic        [30:0] s5_alpha_q;
  logic        [24:0] s5_cs2_q;

  assign alpha4_s = $signed(32'(s4_alpha_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_vnq_q   <= 62'(s4_vn_q) * 62'(s4_q_q);
      s5_aq_q    <= 63'(alpha4_s) * 63'(s4_q_q);
      s5_mat_q   <= s4_mat_q;
      s5_nb_q    <= s4_nb_q;
      s5_w_q     <= s4_w_q;
      s5_omv_q   <= s4_omv_q;
      s5_alpha_q <= s4_alpha_q;
      s5_cs2_q   <= s4_cs2_q;
    end
  end

  // stage 6
  logic signed [62:0] ix_d;
  logic signed [35:0] s6_inner_q;
  logic               s6_badw_q;
  logic signed [62:0] s6_aq_q;
  logic signed [31:0] s6_mat_q;
  logic signed [35:0] s6_nb_q;
  logic signed [27:0] s6_w_q;
  logic signed [25:0] s6_omv_q;
  logic        [30:0] s6_alpha_q;
  logic        [24:0] s6_cs2_q;

  assign ix_d = 63'($signed({s5_w_q, {rcs_pkg::QF{1'b0}}})) - 63'(s5_vnq_q)
              + 63'(rcs_pkg::Q_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_inner_q <= 36'(ix_d >>> rcs_pkg::QF);
      s6_badw_q  <= (s5_w_q <= 28'sd0);
      s6_aq_q    <= s5_aq_q;
      s6_mat_q   <= s5_mat_q;
      s6_nb_q    <= s5_nb_q;
      s6_w_q     <= s5_w_q;
      s6_omv_q   <= s5_omv_q;
      s6_alpha_q <= s5_alpha_q;
      s6_cs2_q   <= s5_cs2_q;
    end
  end

  // stage 7
  logic signed [61:0] r_d;
  logic               bad_d;
  rcs_pkg::front_t    fr_d;
  rcs_pkg::front_t    fr_q;

  always_comb begin
    r_d   = 62'(s6_omv_q) * 62'(s6_inner_q);
    bad_d = s6_badw_q || r_d[61];
    fr_d.rad_c      = 64'({s6_cs2_q, {rcs_pkg::QF{1'b0}}});
    fr_d.rad_r      = bad_d ? 64'd0 : {2'b00, r_d};
    fr_d.side.alpha = s6_alpha_q;
    fr_d.side.aq    = s6_aq_q;
    fr_d.side.nb    = s6_nb_q;
    fr_d.side.mat   = s6_mat_q;
    fr_d.side.w     = bad_d ? 25'd1 : s6_w_q[24:0];
    fr_d.side.bad   = bad_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_q <= fr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  assign vld_o = vld_q[6];
  assign fr_o  = fr_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rcs_sqrt.sv =====
// Pipelined two-lane integer square root, four root bits per stage.
`default_nettype none
module rcs_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  rcs_pkg::front_t   fr_i,
  output logic              vld_o,
  output logic [31:0]       root_c_o,
  output logic [31:0]       root_r_o,
  output rcs_pkg::sq_side_t side_o
);

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } lane_t;

  function automatic lane_t sq_step(lane_t a);
    lane_t       x;
    logic [35:0] trial;
    x = a;
    for (int j = 0; j < rcs_pkg::SQ_STEPS; j++) begin
      x.rem = {x.rem[33:0], x.rad[63:62]};
      x.rad = {x.rad[61:0], 2'b00};
      trial = {2'b00, x.root, 2'b01};
      if (x.rem >= trial) begin
        x.rem  = x.rem - trial;
        x.root = {x.root[30:0], 1'b1};
      end else begin
        x.root = {x.root[30:0], 1'b0};
      end
    end
    return x;
  endfunction

  lane_t             lane_in [rcs_pkg::SQ_STAGES][2];
  lane_t             lane_q  [rcs_pkg::SQ_STAGES][2];
  rcs_pkg::sq_side_t side_in [rcs_pkg::SQ_STAGES];
  rcs_pkg::sq_side_t side_q  [rcs_pkg::SQ_STAGES];
  logic [rcs_pkg::SQ_STAGES-1:0] vld_q;

  for (genvar s = 0; s < rcs_pkg::SQ_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        lane_in[s][0] = '{rem: '0, root: '0, rad: fr_i.rad_c};
        lane_in[s][1] = '{rem: '0, root: '0, rad: fr_i.rad_r};
        side_in[s]    = fr_i.side;
      end
    end else begin : g_rest
      always_comb begin
        lane_in[s][0] = lane_q[s-1][0];
        lane_in[s][1] = lane_q[s-1][1];
        side_in[s]    = side_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q[s][0] <= sq_step(lane_in[s][0]);
        lane_q[s][1] <= sq_step(lane_in[s][1]);
        side_q[s]    <= side_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[rcs_pkg::SQ_STAGES-2:0], vld_i};
    end
  end

  assign vld_o    = vld_q[rcs_pkg::SQ_STAGES-1];
  assign root_c_o = lane_q[rcs_pkg::SQ_STAGES-1][0].root;
  assign root_r_o = lane_q[rcs_pkg::SQ_STAGES-1][1].root;
  assign side_o   = side_q[rcs_pkg::SQ_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rcs_div.sv =====
// Pipelined two-lane restoring divider by the shared positive divisor.
`default_nettype none
module rcs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [63:0] num_f_i,
  input  logic signed [63:0] num_b_i,
  input  logic        [24:0] w_i,
  input  rcs_pkg::div_side_t side_i,
  output logic               vld_o,
  output rcs_pkg::div_res_t  res_f_o,
  output rcs_pkg::div_res_t  res_b_o,
  output rcs_pkg::div_side_t side_o
);

  localparam int QB = rcs_pkg::DIV_QBITS;
  localparam int NS = rcs_pkg::DIV_STAGES;

  typedef struct packed {
    logic [24:0]   rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quot;
    logic          neg;
    logic          ovf;
  } lane_t;

  function automatic lane_t dv_entry(logic signed [63:0] num, logic [24:0] w);
    lane_t       x;
    logic [63:0] mag;
    mag    = num[63] ? 64'(-num) : 64'(num);
    x.neg  = num[63];
    x.ovf  = (25'(mag[62:QB]) >= w);
    x.rem  = x.ovf ? 25'd0 : 25'(mag[62:QB]);
    x.low  = mag[QB-1:0];
    x.quot = '0;
    return x;
  endfunction

  function automatic lane_t dv_step(lane_t a, logic [24:0] w);
    lane_t       x;
    logic [25:0] t;
    logic        b;
    x = a;
    for (int j = 0; j < rcs_pkg::DIV_STEPS; j++) begin
      t     = {x.rem, x.low[QB-1]};
      x.low = {x.low[QB-2:0], 1'b0};
      b     = (t >= {1'b0, w});
      if (b) begin
        x.rem = 25'(t - {1'b0, w});
      end else begin
        x.rem = t[24:0];
      end
      x.quot = {x.quot[QB-2:0], b};
    end
    return x;
  endfunction

  lane_t              ent_q [2];
  logic [24:0]        ent_w_q;
  rcs_pkg::div_side_t ent_side_q;

  lane_t              stg_in  [NS][2];
  logic [24:0]        w_in    [NS];
  rcs_pkg::div_side_t side_in [NS];
  lane_t              stg_q   [NS][2];
  logic [24:0]        w_q     [NS];
  rcs_pkg::div_side_t side_q  [NS];
  logic [NS:0]        vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q[0]   <= dv_entry(num_f_i, w_i);
      ent_q[1]   <= dv_entry(num_b_i, w_i);
      ent_w_q    <= w_i;
      ent_side_q <= side_i;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        stg_in[s][0] = ent_q[0];
        stg_in[s][1] = ent_q[1];
        w_in[s]      = ent_w_q;
        side_in[s]   = ent_side_q;
      end
    end else begin : g_rest
      always_comb begin
        stg_in[s][0] = stg_q[s-1][0];
        stg_in[s][1] = stg_q[s-1][1];
        w_in[s]      = w_q[s-1];
        side_in[s]   = side_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s][0] <= dv_step(stg_in[s][0], w_in[s]);
        stg_q[s][1] <= dv_step(stg_in[s][1], w_in[s]);
        w_q[s]      <= w_in[s];
        side_q[s]   <= side_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], vld_i};
    end
  end

  assign vld_o   = vld_q[NS];
  assign res_f_o = '{quot: stg_q[NS-1][0].quot, neg: stg_q[NS-1][0].neg,
                     ovf: stg_q[NS-1][0].ovf};
  assign res_b_o = '{quot: stg_q[NS-1][1].quot, neg: stg_q[NS-1][1].neg,
                     ovf: stg_q[NS-1][1].ovf};
  assign side_o  = side_q[NS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/relativistic_char_speeds.sv =====
// Top level: characteristic speeds of the relativistic Euler system per grid point.
//
//   channel | dir | beat
//   --------+-----+---------------------------------------------------------
//   in_i    | in  | lapse, shift, velocity, v^2, cs^2, normal (Qm.24; shift Q8.24)
//   out_o   | out | speed_minus, speed_material, speed_plus, invalid_flag
//
// One beat per cycle in and out while out_o is not stalled. The stages are 7 front
// stages, 8 square root stages (four root bits each), 3 scaling stages, 15 divider
// stages (an entry stage, then three quotient bits each), one clamp stage and the output register.
// Reset clears only the valid bits; no data state survives between beats.
// A stall on out_o freezes every stage together; in_i.ready is low only while a
// finished beat waits in the output register.
`default_nettype none
module relativistic_char_speeds (
  input  logic      clk_i,
  input  logic      rst_ni,
  rcs_in_if.sink    in_i,
  rcs_out_if.source out_o
);

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  rcs_pkg::in_t in_s;

  always_comb begin
    in_s.lapse_value = in_i.lapse_value;
    in_s.shift_x     = in_i.shift_x;
    in_s.shift_y     = in_i.shift_y;
    in_s.shift_z     = in_i.shift_z;
    in_s.vel_x       = in_i.vel_x;
    in_s.vel_y       = in_i.vel_y;
    in_s.vel_z       = in_i.vel_z;
    in_s.vel_sq      = in_i.vel_sq;
    in_s.sound_sq    = in_i.sound_sq;
    in_s.norm_x      = in_i.norm_x;
    in_s.norm_y      = in_i.norm_y;
    in_s.norm_z      = in_i.norm_z;
  end

  logic            fr_vld;
  rcs_pkg::front_t fr;

  rcs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .in_i   (in_s),
    .vld_o  (fr_vld),
    .fr_o   (fr)
  );

  logic              sq_vld;
  logic [31:0]       root_c;
  logic [31:0]       root_r;
  rcs_pkg::sq_side_t sq_side;

  rcs_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (fr_vld),
    .fr_i     (fr),
    .vld_o    (sq_vld),
    .root_c_o (root_c),
    .root_r_o (root_r),
    .side_o   (sq_side)
  );

  // scale the acoustic root: p = rnd(alpha * s1), then p * s2
  logic [2:0]        p_vld_q;
  logic [55:0]       p1_as_q;
  logic [31:0]       p1_s2_q;
  logic [31:0]       p2_s2_q;
  logic [31:0]       p2_p_q;
  logic [63:0]       p3_ps_q;
  rcs_pkg::sq_side_t p1_side_q;
  rcs_pkg::sq_side_t p2_side_q;
  rcs_pkg::sq_side_t p3_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_as_q   <= 56'(sq_side.alpha) * 56'(root_c[24:0]);
      p1_s2_q   <= root_r;
      p1_side_q <= sq_side;
      p2_p_q    <= 32'((p1_as_q + 56'(rcs_pkg::Q_HALF_U)) >> rcs_pkg::QF);
      p2_s2_q   <= p1_s2_q;
      p2_side_q <= p1_side_q;
      p3_ps_q   <= 64'(p2_p_q) * 64'(p2_s2_q);
      p3_side_q <= p2_side_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= '0;
    end else if (en) begin
      p_vld_q <= {p_vld_q[1:0], sq_vld};
    end
  end

  logic               dv_vld;
  rcs_pkg::div_res_t  res_f;
  rcs_pkg::div_res_t  res_b;
  rcs_pkg::div_side_t dv_side_in;
  rcs_pkg::div_side_t dv_side;

  assign dv_side_in = '{nb: p3_side_q.nb, mat: p3_side_q.mat, bad: p3_side_q.bad};

  rcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (p_vld_q[2]),
    .num_f_i (64'(p3_side_q.aq)),
    .num_b_i ($signed({1'b0, p3_ps_q[62:0]})),
    .w_i     (p3_side_q.w),
    .side_i  (dv_side_in),
    .vld_o   (dv_vld),
    .res_f_o (res_f),
    .res_b_o (res_b),
    .side_o  (dv_side)
  );

  function automatic logic signed [41:0] term(rcs_pkg::div_res_t r);
    logic [41:0] mag;
    mag = (r.ovf || (r.quot > rcs_pkg::TERM_LIM)) ? rcs_pkg::TERM_LIM : r.quot;
    return r.neg ? -$signed(mag) : $signed(mag);
  endfunction

  logic               t_vld_q;
  logic signed [41:0] t_f_q;
  logic signed [41:0] t_b_q;
  rcs_pkg::div_side_t t_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_f_q    <= term(res_f);
      t_b_q    <= term(res_b);
      t_side_q <= dv_side;
    end
  end

  logic signed [44:0] sum_p;
  logic signed [44:0] sum_m;
  logic signed [31:0] minus_q;
  logic signed [31:0] mat_q;
  logic signed [31:0] plus_q;
  logic               bad_q;

  assign sum_p = -45'(t_side_q.nb) + 45'(t_f_q) + 45'(t_b_q);
  assign sum_m = -45'(t_side_q.nb) + 45'(t_f_q) - 45'(t_b_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mat_q   <= t_side_q.mat;
      bad_q   <= t_side_q.bad;
      minus_q <= t_side_q.bad ? t_side_q.mat : rcs_pkg::sat32(64'(sum_m));
      plus_q  <= t_side_q.bad ? t_side_q.mat : rcs_pkg::sat32(64'(sum_p));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      t_vld_q   <= dv_vld;
      out_vld_q <= t_vld_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.speed_minus    = minus_q;
  assign out_o.speed_material = mat_q;
  assign out_o.speed_plus     = plus_q;
  assign out_o.invalid_flag   = bad_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rcs_checker.sv =====
// Port-level checks for the characteristic speed block, bound to the top level.
`default_nettype none
module rcs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] minus_i,
  input logic signed [31:0] mat_i,
  input logic signed [31:0] plus_i,
  input logic               invalid_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && invalid_i |-> (minus_i == mat_i) && (plus_i == mat_i))
    else $error("invalid beat with acoustic speeds off the material speed");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !invalid_i |-> minus_i <= plus_i)
    else $error("slow speed above fast speed");

endmodule

bind relativistic_char_speeds rcs_checker u_rcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .minus_i     (out_o.speed_minus),
  .mat_i       (out_o.speed_material),
  .plus_i      (out_o.speed_plus),
  .invalid_i   (out_o.invalid_flag)
);
`default_nettype wire
